@@ rtl/sped_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the
// satellite pass elevation detector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sped_pkg;

  // Field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int ALT_W  = 20;
  localparam int TIME_W = 32;
  localparam int ELEV_W = 24;
  localparam int STAT_W = 3;

  // Internal angles are degrees * 2^IFRAC; datapath words are D_W bits signed
  localparam int IFRAC = 24;
  localparam int D_W   = 34;

  localparam logic signed [D_W-1:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [D_W-1:0] RE_KM4096  = 34'sd26095616;
  localparam logic [ALT_W:0]        RADIUS_X16 = 21'd101936;

  localparam longint FULL_TURN    = 64'sd6039797760;
  localparam longint HALF_TURN    = 64'sd3019898880;
  localparam longint QUARTER_TURN = 64'sd1509949440;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OBS_LAT = 2'd0;
  localparam logic [1:0] REG_OBS_LON = 2'd1;
  localparam logic [1:0] REG_MIN_EL  = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_SEARCHING  = 3'd0,
    ST_VISIBLE    = 3'd1,
    ST_PASS_FOUND = 3'd2,
    ST_NO_PASS    = 3'd3,
    ST_IDLE       = 3'd4
  } search_status_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_LOAD, BK_REDUCE, BK_FOLD, BK_ROT, BK_MUL, BK_FIX,
    BK_VEC1, BK_GAIN, BK_CHK, BK_VEC2, BK_ROUND, BK_OUT
  } bk_state_e;

  typedef enum logic [1:0] {
    ANG_OBS_LAT, ANG_SAT_LAT, ANG_DLON
  } ang_sel_e;

  typedef enum logic [3:0] {
    MS_Q, MS_T1, MS_T2, MS_T3, MS_T4, MS_T5, MS_SUM, MS_DU, MS_DE, MS_DN
  } mul_step_e;

  typedef struct packed {
    logic signed [LAT_W-1:0] sat_lat;
    logic signed [LON_W-1:0] sat_lon;
    logic [ALT_W-1:0]        sat_alt_km;
    logic                    pos_valid;
    logic [TIME_W-1:0]       sample_time;
    logic                    first_sample;
    logic                    last_sample;
  } item_t;

  typedef struct packed {
    logic  calc;
    item_t item;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] min_el;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic                  vect;
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
    logic signed [D_W-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
    logic signed [D_W-1:0] z;
  } cordic_rsp_t;

  // atan(2^-i) in degrees * 2^24
  function automatic logic signed [D_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [D_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sd754974720;
      5'd1:    v = 34'sd445687602;
      5'd2:    v = 34'sd235489088;
      5'd3:    v = 34'sd119537938;
      5'd4:    v = 34'sd60000934;
      5'd5:    v = 34'sd30029717;
      5'd6:    v = 34'sd15018523;
      5'd7:    v = 34'sd7509720;
      5'd8:    v = 34'sd3754917;
      5'd9:    v = 34'sd1877466;
      5'd10:   v = 34'sd938734;
      5'd11:   v = 34'sd469367;
      5'd12:   v = 34'sd234684;
      5'd13:   v = 34'sd117342;
      5'd14:   v = 34'sd58671;
      5'd15:   v = 34'sd29335;
      5'd16:   v = 34'sd14668;
      5'd17:   v = 34'sd7334;
      5'd18:   v = 34'sd3667;
      5'd19:   v = 34'sd1833;
      5'd20:   v = 34'sd917;
      5'd21:   v = 34'sd458;
      5'd22:   v = 34'sd229;
      5'd23:   v = 34'sd115;
      5'd24:   v = 34'sd57;
      5'd25:   v = 34'sd29;
      5'd26:   v = 34'sd14;
      5'd27:   v = 34'sd7;
      5'd28:   v = 34'sd4;
      5'd29:   v = 34'sd2;
      5'd30:   v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sped_ifs.sv @@
// Valid/ready channel interfaces for sample words in and result words out.
// Depends on sped_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sped_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sped_pkg::LAT_W-1:0] sat_lat;
  logic signed [sped_pkg::LON_W-1:0] sat_lon;
  logic [sped_pkg::ALT_W-1:0]        sat_alt_km;
  logic                              pos_valid;
  logic [sped_pkg::TIME_W-1:0]       sample_time;
  logic                              first_sample;
  logic                              last_sample;

  modport source (output valid, sat_lat, sat_lon, sat_alt_km, pos_valid, sample_time,
                  first_sample, last_sample, input ready);
  modport sink (input valid, sat_lat, sat_lon, sat_alt_km, pos_valid, sample_time,
                first_sample, last_sample, output ready);
endinterface

interface sped_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sped_pkg::ELEV_W-1:0] elevation;
  logic [sped_pkg::STAT_W-1:0]        search_status;
  logic [sped_pkg::TIME_W-1:0]        pass_time;

  modport source (output valid, elevation, search_status, pass_time, input ready);
  modport sink (input valid, elevation, search_status, pass_time, output ready);
endinterface

`default_nettype wire

@@ rtl/sped_front.sv @@
// Front end: accepts sample words, marks which need the full solve and
// holds them in a two-entry queue for the back end. Depends on sped_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sped_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sped_in_if.sink                    in_ch,
  output sped_pkg::queue_head_t      head_o,
  input  wire logic                  pop_i
);

  sped_pkg::q_entry_t mem_q [2];
  sped_pkg::q_entry_t new_entry;
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               push, pop;

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = pop_i && (cnt_q != 2'd0);

  always_comb begin
    new_entry.item.sat_lat      = in_ch.sat_lat;
    new_entry.item.sat_lon      = in_ch.sat_lon;
    new_entry.item.sat_alt_km   = in_ch.sat_alt_km;
    new_entry.item.pos_valid    = in_ch.pos_valid;
    new_entry.item.sample_time  = in_ch.sample_time;
    new_entry.item.first_sample = in_ch.first_sample;
    new_entry.item.last_sample  = in_ch.last_sample;
    // invalid positions skip the trigonometry altogether
    new_entry.calc              = in_ch.pos_valid;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ rtl/sped_cordic.sv @@
// Iterative CORDIC unit, one micro-rotation per cycle, in rotation or
// vectoring mode. Depends on sped_pkg for the word width and atan table.
`timescale 1ns / 1ps
`default_nettype none

module sped_cordic #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sped_pkg::cordic_req_t req_i,
  output sped_pkg::cordic_rsp_t      rsp_o
);

  localparam int CW = $clog2(CORDIC_ITERATIONS + 1);
  localparam logic [CW-1:0] LAST = CW'(CORDIC_ITERATIONS - 1);

  logic signed [sped_pkg::D_W-1:0] x_q, y_q, z_q;
  logic signed [sped_pkg::D_W-1:0] dx, dy, at;
  logic [CW-1:0]                   cnt_q;
  logic [4:0]                      sh;
  logic                            run_q, done_q, vect_q, plus;

  assign sh   = 5'(cnt_q);
  assign dx   = y_q >>> sh;
  assign dy   = x_q >>> sh;
  assign at   = sped_pkg::atan_deg(sh);
  // rotate towards z = 0, or towards y = 0 when vectoring
  assign plus = vect_q ? y_q[sped_pkg::D_W-1] : !z_q[sped_pkg::D_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == LAST);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.x;
      y_q    <= req_i.y;
      z_q    <= req_i.z;
      vect_q <= req_i.vect;
    end else if (run_q) begin
      if (plus) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = x_q;
  assign rsp_o.y    = y_q;
  assign rsp_o.z    = z_q;

endmodule

`default_nettype wire

@@ rtl/sped_back.sv @@
// Back end: sequences angle reduction, the shared CORDIC unit and one shared
// multiplier to get the elevation, then runs the pass search and holds the
// result word. Depends on sped_pkg and sped_cordic.
`timescale 1ns / 1ps
`default_nettype none

module sped_back #(
  parameter int ANGLE_FRAC_BITS   = 16,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sped_pkg::cfg_t        cfg_i,
  input  wire sped_pkg::queue_head_t head_i,
  output logic                       pop_o,
  sped_out_if.source                 out_ch
);

  localparam int D_W   = sped_pkg::D_W;
  localparam int SH    = sped_pkg::IFRAC - ANGLE_FRAC_BITS;
  localparam int ANG_W = (27 + SH > 35) ? 27 + SH : 35;

  localparam logic signed [ANG_W-1:0] FULL    = ANG_W'(sped_pkg::FULL_TURN);
  localparam logic signed [ANG_W-1:0] HALF    = ANG_W'(sped_pkg::HALF_TURN);
  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(sped_pkg::QUARTER_TURN);
  localparam logic signed [D_W-1:0]   LIM     = D_W'(sped_pkg::QUARTER_TURN);
  localparam logic signed [D_W-1:0]   RND     = D_W'((64'sd1 <<< SH) >>> 1);
  localparam logic signed [D_W-1:0]   ELEV_INV = D_W'(-(64'sd90 <<< ANGLE_FRAC_BITS));

  sped_pkg::bk_state_e   state_q, state_d;
  sped_pkg::ang_sel_e    ang_q;
  sped_pkg::mul_step_e   mstep_q;
  sped_pkg::item_t       it_q;
  sped_pkg::cordic_req_t creq;
  sped_pkg::cordic_rsp_t crsp;
  sped_pkg::search_status_e status;

  logic signed [ANG_W-1:0] red_q, fold_v;
  logic                    fold_flip, flip_q;
  logic signed [D_W-1:0]   co_q, so_q, cs_q, ss_q, cd_q, sd_q;
  logic signed [D_W-1:0]   q_q, t1_q, t2_q, t3_q, t4_q, t5_q, s1_q, s2_q;
  logic signed [D_W-1:0]   du_q, de_q, dn_q, h_q, z_q, elev_q;
  logic signed [D_W-1:0]   ma, mb, mq, r_v, cx, cy, zc, abs_de;
  logic signed [2*D_W-1:0] prod;
  logic                    idle_q, idle_d, meets, write_out;
  logic [sped_pkg::TIME_W-1:0] ptime;

  logic                               out_valid_q;
  logic signed [sped_pkg::ELEV_W-1:0] out_elev_q;
  logic [sped_pkg::STAT_W-1:0]        out_stat_q;
  logic [sped_pkg::TIME_W-1:0]        out_time_q;

  sped_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .rsp_o (crsp)
  );

  // orbit radius in km * 4096
  assign r_v = D_W'({1'b0, it_q.sat_alt_km} + sped_pkg::RADIUS_X16) <<< 8;

  always_comb begin
    if (red_q > QUARTER) begin
      fold_v    = red_q - HALF;
      fold_flip = 1'b1;
    end else if (red_q < -QUARTER) begin
      fold_v    = red_q + HALF;
      fold_flip = 1'b1;
    end else begin
      fold_v    = red_q;
      fold_flip = 1'b0;
    end
  end

  assign cx     = flip_q ? -crsp.x : crsp.x;
  assign cy     = flip_q ? -crsp.y : crsp.y;
  assign abs_de = de_q[D_W-1] ? -de_q : de_q;

  // shared multiplier, Q30 product with floor rounding
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == sped_pkg::BK_GAIN) begin
      ma = crsp.x;
      mb = sped_pkg::GAIN_Q30;
    end else begin
      case (mstep_q)
        sped_pkg::MS_Q:  begin ma = cs_q; mb = cd_q; end
        sped_pkg::MS_T1: begin ma = co_q; mb = q_q;  end
        sped_pkg::MS_T2: begin ma = so_q; mb = ss_q; end
        sped_pkg::MS_T3: begin ma = cs_q; mb = sd_q; end
        sped_pkg::MS_T4: begin ma = co_q; mb = ss_q; end
        sped_pkg::MS_T5: begin ma = so_q; mb = q_q;  end
        sped_pkg::MS_DU: begin ma = r_v;  mb = s1_q; end
        sped_pkg::MS_DE: begin ma = r_v;  mb = t3_q; end
        sped_pkg::MS_DN: begin ma = r_v;  mb = s2_q; end
        default:         begin ma = '0;   mb = '0;   end
      endcase
    end
  end

  assign prod = ma * mb;
  assign mq   = D_W'(prod >>> 30);

  always_comb begin
    if (z_q > LIM) begin
      zc = LIM;
    end else if (z_q < -LIM) begin
      zc = -LIM;
    end else begin
      zc = z_q;
    end
  end

  // pass search on the finished elevation
  always_comb begin
    meets  = elev_q >= D_W'(cfg_i.min_el);
    ptime  = '0;
    idle_d = idle_q;
    if (!it_q.first_sample && idle_q) begin
      status = sped_pkg::ST_IDLE;
    end else if (meets) begin
      status = it_q.first_sample ? sped_pkg::ST_VISIBLE : sped_pkg::ST_PASS_FOUND;
      ptime  = it_q.sample_time;
      idle_d = 1'b1;
    end else if (it_q.last_sample) begin
      status = sped_pkg::ST_NO_PASS;
      idle_d = 1'b1;
    end else begin
      status = sped_pkg::ST_SEARCHING;
      idle_d = 1'b0;
    end
  end

  assign write_out = (state_q == sped_pkg::BK_OUT) && (!out_valid_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    creq    = '0;
    case (state_q)
      sped_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = head_i.entry.calc ? sped_pkg::BK_LOAD : sped_pkg::BK_OUT;
        end
      end
      sped_pkg::BK_LOAD: state_d = sped_pkg::BK_REDUCE;
      sped_pkg::BK_REDUCE: begin
        if (!(red_q >= HALF) && !(red_q < -HALF)) begin
          state_d = sped_pkg::BK_FOLD;
        end
      end
      sped_pkg::BK_FOLD: begin
        creq.start = 1'b1;
        creq.vect  = 1'b0;
        creq.x     = sped_pkg::GAIN_Q30;
        creq.y     = '0;
        creq.z     = D_W'(fold_v);
        state_d    = sped_pkg::BK_ROT;
      end
      sped_pkg::BK_ROT: begin
        if (crsp.done) begin
          state_d = (ang_q == sped_pkg::ANG_DLON) ? sped_pkg::BK_MUL : sped_pkg::BK_LOAD;
        end
      end
      sped_pkg::BK_MUL: begin
        if (mstep_q == sped_pkg::MS_DN) begin
          state_d = sped_pkg::BK_FIX;
        end
      end
      sped_pkg::BK_FIX: begin
        creq.start = 1'b1;
        creq.vect  = 1'b1;
        creq.x     = abs_de;
        creq.y     = dn_q;
        creq.z     = '0;
        state_d    = sped_pkg::BK_VEC1;
      end
      sped_pkg::BK_VEC1: begin
        if (crsp.done) begin
          state_d = sped_pkg::BK_GAIN;
        end
      end
      sped_pkg::BK_GAIN: state_d = sped_pkg::BK_CHK;
      sped_pkg::BK_CHK: begin
        // satellite right at the observer: elevation stays zero
        if (h_q == '0 && du_q == '0) begin
          state_d = sped_pkg::BK_ROUND;
        end else begin
          creq.start = 1'b1;
          creq.vect  = 1'b1;
          creq.x     = h_q;
          creq.y     = du_q;
          creq.z     = '0;
          state_d    = sped_pkg::BK_VEC2;
        end
      end
      sped_pkg::BK_VEC2: begin
        if (crsp.done) begin
          state_d = sped_pkg::BK_ROUND;
        end
      end
      sped_pkg::BK_ROUND: state_d = sped_pkg::BK_OUT;
      sped_pkg::BK_OUT: begin
        if (write_out) begin
          state_d = sped_pkg::BK_IDLE;
        end
      end
      default: state_d = sped_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sped_pkg::BK_IDLE;
      ang_q       <= sped_pkg::ANG_OBS_LAT;
      mstep_q     <= sped_pkg::MS_Q;
      idle_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == sped_pkg::BK_IDLE) begin
        ang_q <= sped_pkg::ANG_OBS_LAT;
      end else if (state_q == sped_pkg::BK_ROT && crsp.done) begin
        if (ang_q == sped_pkg::ANG_DLON) begin
          mstep_q <= sped_pkg::MS_Q;
        end else begin
          ang_q <= sped_pkg::ang_sel_e'(ang_q + 2'd1);
        end
      end
      if (state_q == sped_pkg::BK_MUL && mstep_q != sped_pkg::MS_DN) begin
        mstep_q <= sped_pkg::mul_step_e'(mstep_q + 4'd1);
      end
      if (write_out) begin
        idle_q      <= idle_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      sped_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          it_q   <= head_i.entry.item;
          elev_q <= ELEV_INV;
        end
      end
      sped_pkg::BK_LOAD: begin
        case (ang_q)
          sped_pkg::ANG_OBS_LAT: red_q <= ANG_W'(cfg_i.lat) <<< SH;
          sped_pkg::ANG_SAT_LAT: red_q <= ANG_W'(it_q.sat_lat) <<< SH;
          default: red_q <= (ANG_W'(it_q.sat_lon) <<< SH) - (ANG_W'(cfg_i.lon) <<< SH);
        endcase
      end
      sped_pkg::BK_REDUCE: begin
        if (red_q >= HALF) begin
          red_q <= red_q - FULL;
        end else if (red_q < -HALF) begin
          red_q <= red_q + FULL;
        end
      end
      sped_pkg::BK_FOLD: flip_q <= fold_flip;
      sped_pkg::BK_ROT: begin
        if (crsp.done) begin
          case (ang_q)
            sped_pkg::ANG_OBS_LAT: begin co_q <= cx; so_q <= cy; end
            sped_pkg::ANG_SAT_LAT: begin cs_q <= cx; ss_q <= cy; end
            default:               begin cd_q <= cx; sd_q <= cy; end
          endcase
        end
      end
      sped_pkg::BK_MUL: begin
        case (mstep_q)
          sped_pkg::MS_Q:   q_q  <= mq;
          sped_pkg::MS_T1:  t1_q <= mq;
          sped_pkg::MS_T2:  t2_q <= mq;
          sped_pkg::MS_T3:  t3_q <= mq;
          sped_pkg::MS_T4:  t4_q <= mq;
          sped_pkg::MS_T5:  t5_q <= mq;
          sped_pkg::MS_SUM: begin
            s1_q <= t1_q + t2_q;
            s2_q <= t4_q - t5_q;
          end
          sped_pkg::MS_DU:  du_q <= mq;
          sped_pkg::MS_DE:  de_q <= mq;
          sped_pkg::MS_DN:  dn_q <= mq;
          default:          q_q  <= q_q;
        endcase
      end
      sped_pkg::BK_FIX:  du_q <= du_q - sped_pkg::RE_KM4096;
      sped_pkg::BK_GAIN: h_q  <= mq;
      sped_pkg::BK_CHK: begin
        if (h_q == '0 && du_q == '0) begin
          z_q <= '0;
        end
      end
      sped_pkg::BK_VEC2: begin
        if (crsp.done) begin
          z_q <= crsp.z;
        end
      end
      sped_pkg::BK_ROUND: elev_q <= (zc + RND) >>> SH;
      default: ;
    endcase
    if (write_out) begin
      out_elev_q <= elev_q[sped_pkg::ELEV_W-1:0];
      out_stat_q <= status;
      out_time_q <= ptime;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.elevation     = out_elev_q;
  assign out_ch.search_status = out_stat_q;
  assign out_ch.pass_time     = out_time_q;

endmodule

`default_nettype wire

@@ rtl/satellite_pass_elevation_detector_unit.sv @@
// Top level of the satellite pass elevation detector: configuration
// registers on an APB-style port, front end queue and back end solver.
// Depends on sped_pkg, sped_ifs, sped_front and sped_back.
`timescale 1ns / 1ps
`default_nettype none

// Each sample word gives one result word: the topocentric elevation of the
// satellite seen from the configured observer, and the pass search status.
// A valid sample is solved in the back end by the single CORDIC unit, which
// runs three sine/cosine passes and two vectoring passes one micro-rotation
// per cycle; each angle reduction takes one step per 360-degree wrap, and a
// satellite right at the observer skips the second vectoring pass. An
// invalid sample skips the solve and goes straight to the output state. A
// two-entry queue takes new words while the back end works, and a result
// register holds the finished word until it is taken. Registers:
// observer_lat at 0x0, observer_lon at 0x4, min_elevation at 0x8; write
// them only while no sample is in flight.
module satellite_pass_elevation_detector_unit #(
  parameter int ANGLE_FRAC_BITS   = 16,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sped_in_if.sink          in_ch,
  sped_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [sped_pkg::LAT_W-1:0] obs_lat_q;
  logic [sped_pkg::LON_W-1:0] obs_lon_q;
  logic [sped_pkg::LAT_W-1:0] min_el_q;
  logic                       wr_en;
  sped_pkg::cfg_t             cfg;
  sped_pkg::queue_head_t      head;
  logic                       pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_lat_q <= '0;
      obs_lon_q <= '0;
      min_el_q  <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        sped_pkg::REG_OBS_LAT: obs_lat_q <= pwdata[sped_pkg::LAT_W-1:0];
        sped_pkg::REG_OBS_LON: obs_lon_q <= pwdata[sped_pkg::LON_W-1:0];
        sped_pkg::REG_MIN_EL:  min_el_q  <= pwdata[sped_pkg::LAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sped_pkg::REG_OBS_LAT: prdata = 32'(obs_lat_q);
      sped_pkg::REG_OBS_LON: prdata = 32'(obs_lon_q);
      sped_pkg::REG_MIN_EL:  prdata = 32'(min_el_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg.lat    = obs_lat_q;
  assign cfg.lon    = obs_lon_q;
  assign cfg.min_el = min_el_q;

  sped_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .head_o(head),
    .pop_i (pop)
  );

  sped_back #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .head_i(head),
    .pop_o (pop),
    .out_ch(out_ch)
  );

endmodule

`default_nettype wire

@@ sim/tb_satellite_pass_elevation_detector_unit.sv @@
// Testbench for the satellite pass elevation detector: drives sample words and
// register writes, predicts each result word and checks it on arrival.
// Depends on sped_pkg, sped_ifs and the satellite_pass_elevation_detector_unit RTL.
`timescale 1ns / 1ps

module tb_satellite_pass_elevation_detector_unit;

  localparam longint DEG_TURN   = 64'sd6039797760;
  localparam longint DEG_HALF   = 64'sd3019898880;
  localparam longint DEG_QUART  = 64'sd1509949440;
  localparam longint CORDIC_K   = 64'sd652032874;
  localparam int     N_ROT      = 24;
  localparam longint ELEV_FLOOR = -64'sd5898240;
  localparam longint ATAN_DEG[32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0};

  class pass_scoreboard;
    typedef struct {
      logic signed [sped_pkg::ELEV_W-1:0] elev;
      sped_pkg::search_status_e           status;
      logic [sped_pkg::TIME_W-1:0]        ptime;
    } result_t;

    result_t                           awaited[$];
    bit                                window_shut;
    logic signed [sped_pkg::LAT_W-1:0] obs_lat;
    logic signed [sped_pkg::LON_W-1:0] obs_lon;
    logic signed [sped_pkg::LAT_W-1:0] min_el;
    int                                errors;

    function new();
      window_shut = 1;
      obs_lat = '0;
      obs_lon = '0;
      min_el = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        sped_pkg::REG_OBS_LAT: obs_lat = v[sped_pkg::LAT_W-1:0];
        sped_pkg::REG_OBS_LON: obs_lon = v[sped_pkg::LON_W-1:0];
        sped_pkg::REG_MIN_EL:  min_el = v[sped_pkg::LAT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b) >>> 30;
    endfunction

    function void sin_cos(longint a, output longint c, output longint s);
      longint r, x, y, dx, dy;
      bit flip;
      r = a % DEG_TURN;
      flip = 0;
      x = CORDIC_K;
      y = 0;
      if (r < 0) r += DEG_TURN;
      if (r >= DEG_HALF) r -= DEG_TURN;
      if (r > DEG_QUART) begin
        r -= DEG_HALF;
        flip = 1;
      end else if (r < -DEG_QUART) begin
        r += DEG_HALF;
        flip = 1;
      end
      for (int i = 0; i < N_ROT; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          x -= dx; y += dy; r -= ATAN_DEG[i];
        end else begin
          x += dx; y -= dy; r += ATAN_DEG[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint rotate_to_axis(inout longint x, input longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < N_ROT; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_DEG[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_DEG[i];
        end
      end
      return z;
    endfunction

    function longint elevation_of(sped_pkg::item_t it);
      longint co, so, cs, ss, cd, sd, q, r, du, de, dn, h, z, dummy;
      sin_cos(longint'(obs_lat) <<< 8, co, so);
      sin_cos(longint'(it.sat_lat) <<< 8, cs, ss);
      sin_cos((longint'(it.sat_lon) <<< 8) - (longint'(obs_lon) <<< 8), cd, sd);
      r = (64'sd101936 + longint'(it.sat_alt_km)) * 256;
      q = mulq(cs, cd);
      du = mulq(r, mulq(co, q) + mulq(so, ss)) - 64'sd26095616;
      de = mulq(r, mulq(cs, sd));
      dn = mulq(r, mulq(co, ss) - mulq(so, q));
      h = de < 0 ? -de : de;
      dummy = rotate_to_axis(h, dn);
      h = mulq(h, CORDIC_K);
      if (h == 0 && du == 0) z = 0;
      else z = rotate_to_axis(h, du);
      if (z > DEG_QUART) z = DEG_QUART;
      if (z < -DEG_QUART) z = -DEG_QUART;
      return (z + 128) >>> 8;
    endfunction

    function void note_sample(sped_pkg::item_t it);
      result_t res;
      longint  e;
      e = it.pos_valid ? elevation_of(it) : ELEV_FLOOR;
      res.elev = e[sped_pkg::ELEV_W-1:0];
      res.ptime = '0;
      if (!it.first_sample && window_shut) begin
        res.status = sped_pkg::ST_IDLE;
      end else if (e >= longint'(min_el)) begin
        res.status = it.first_sample ? sped_pkg::ST_VISIBLE : sped_pkg::ST_PASS_FOUND;
        res.ptime = it.sample_time;
        window_shut = 1;
      end else if (it.last_sample) begin
        res.status = sped_pkg::ST_NO_PASS;
        window_shut = 1;
      end else begin
        res.status = sped_pkg::ST_SEARCHING;
        window_shut = 0;
      end
      awaited.push_back(res);
    endfunction

    function void check_result(logic signed [sped_pkg::ELEV_W-1:0] elev,
                               logic [sped_pkg::STAT_W-1:0] st,
                               logic [sped_pkg::TIME_W-1:0] pt);
      result_t w;
      if (awaited.size() == 0) begin
        $error("result word with none awaited: elevation %0d status %0d", elev, st);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (elev !== w.elev) begin
        $error("elevation: expected %0d, got %0d", w.elev, elev);
        errors++;
      end
      if (st !== w.status) begin
        $error("search_status: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (pt !== w.ptime) begin
        $error("pass_time: expected %0d, got %0d", w.ptime, pt);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sped_in_if  in_ch ();
  sped_out_if out_ch ();

  satellite_pass_elevation_detector_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pass_scoreboard sb = new();
  bit             hold_sink;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [31:0] lat, logic [31:0] lon, logic [31:0] mel);
    write_reg(sped_pkg::REG_OBS_LAT, lat);
    write_reg(sped_pkg::REG_OBS_LON, lon);
    write_reg(sped_pkg::REG_MIN_EL, mel);
  endtask

  // Gap is drawn here so that valid stays high across back-to-back words.
  task automatic send_word(sped_pkg::item_t it);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sat_lat <= it.sat_lat;
    in_ch.sat_lon <= it.sat_lon;
    in_ch.sat_alt_km <= it.sat_alt_km;
    in_ch.pos_valid <= it.pos_valid;
    in_ch.sample_time <= it.sample_time;
    in_ch.first_sample <= it.first_sample;
    in_ch.last_sample <= it.last_sample;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_sample(it);
  endtask

  function automatic sped_pkg::item_t make_sample(bit near, bit first, bit last);
    sped_pkg::item_t it;
    logic [31:0]     rnd;
    int              ofs;
    rnd = $urandom();
    it.sat_lat = rnd[sped_pkg::LAT_W-1:0];
    rnd = $urandom();
    it.sat_lon = rnd[sped_pkg::LON_W-1:0];
    if (near) begin
      ofs = int'(sb.obs_lat) + int'($urandom_range(0, 2621440)) - 1310720;
      it.sat_lat = ofs[sped_pkg::LAT_W-1:0];
      ofs = int'(sb.obs_lon) + int'($urandom_range(0, 2621440)) - 1310720;
      it.sat_lon = ofs[sped_pkg::LON_W-1:0];
    end
    rnd = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(2400, 40000);
    it.sat_alt_km = rnd[sped_pkg::ALT_W-1:0];
    it.pos_valid = $urandom_range(0, 9) != 0;
    it.sample_time = $urandom();
    it.first_sample = first;
    it.last_sample = last;
    return it;
  endfunction

  task automatic directed_words();
    sped_pkg::item_t it;
    // satellite straight over the observer at zero height
    it = '{sat_lat: sb.obs_lat, sat_lon: sb.obs_lon, sat_alt_km: '0, pos_valid: 1'b1,
           sample_time: '0, first_sample: 1'b1, last_sample: 1'b0};
    send_word(it);
    it.sat_alt_km = 20'hFFFFF;
    it.sample_time = 32'hFFFFFFFF;
    send_word(it);
    it.first_sample = 1'b0;
    send_word(it);
    // invalid sample opening and closing a window
    it.pos_valid = 1'b0;
    it.first_sample = 1'b1;
    it.last_sample = 1'b1;
    send_word(it);
    it.last_sample = 1'b0;
    send_word(it);
    it.first_sample = 1'b0;
    it.sat_lat = 24'h7FFFFF;
    it.sat_lon = 25'h0FFFFFF;
    send_word(it);
    it.pos_valid = 1'b1;
    it.sat_lat = 24'h800000;
    it.sat_lon = 25'h1000000;
    it.sat_alt_km = 20'd6400;
    send_word(it);
    it.sat_lat = 24'sd5898240;
    it.sat_lon = 25'sd11796480;
    it.last_sample = 1'b1;
    send_word(it);
    it.sat_lat = -24'sd5898240;
    it.sat_lon = -25'sd11796480;
    it.first_sample = 1'b1;
    send_word(it);
    it.first_sample = 1'b0;
    it.last_sample = 1'b0;
    send_word(it);
    for (int k = 0; k < 6; k++) send_word(make_sample(1'b1, k == 0, k == 5));
  endtask

  task automatic random_windows(int target);
    int sent, len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise outside a window, or a broken window without an end
        send_word(make_sample($urandom_range(0, 1) != 0, 1'b0, $urandom_range(0, 1) != 0));
        if ($urandom_range(0, 1)) begin
          send_word(make_sample(1'b0, 1'b1, 1'b0));
          sent++;
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_word(make_sample($urandom_range(0, 2) != 0, k == 0,
                                k == len - 1 && $urandom_range(0, 3) != 0));
          sent++;
        end
      end
    end
  endtask

  // Drop valid so the last word is not taken again, then wait for all results.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Sink: random stalls per word, plus one long hold-off to back up the queue.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (2000) @(posedge clk_i);
        hold_sink = 0;
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      sb.check_result(out_ch.elevation, out_ch.search_status, out_ch.pass_time);
    end
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    hold_sink = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sat_lat = '0;
    in_ch.sat_lon = '0;
    in_ch.sat_alt_km = '0;
    in_ch.pos_valid = 1'b0;
    in_ch.sample_time = '0;
    in_ch.first_sample = 1'b0;
    in_ch.last_sample = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(32'd0, 32'd0, 32'd0);
    directed_words();
    hold_sink = 1;
    random_windows(250);
    drain();

    configure(32'sd5898240, 32'sd11796480, -32'sd5898240);
    directed_words();
    random_windows(250);
    drain();

    configure(-32'sd5898240, -32'sd11796480, 32'sd5898240);
    directed_words();
    random_windows(250);
    drain();

    configure(32'h007FFFFF, 32'h00FFFFFF, 32'hFF800000);
    random_windows(200);
    drain();

    configure(32'hFF800000, 32'hFF000000, 32'h007FFFFF);
    random_windows(200);
    drain();

    for (int p = 0; p < 3; p++) begin
      configure($signed($urandom_range(0, 11796480)) - 5898240,
                $signed($urandom_range(0, 23592960)) - 11796480,
                $signed($urandom_range(0, 2621440)) - 655360);
      random_windows(210);
      drain();
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
